// File: rtl/frame_error_check_verifier_defines.svh
// Assertion macros shared by the frame error check verifier RTL.
// Depends on nothing; taken in by files that carry concurrent checks.
`ifndef FRAME_ERROR_CHECK_VERIFIER_DEFINES_SVH
`define FRAME_ERROR_CHECK_VERIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fec_pkg.sv
// Shared types, constants and per-byte update functions for the frame checker.
// No dependencies.
package fec_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] SUM_INIT = 16'h0000;

    typedef enum logic [1:0] {
        METH_PARITY = 2'd0,
        METH_CRC    = 2'd1,
        METH_SUM    = 2'd2
    } t_method;

    typedef struct packed {
        logic        parity;
        logic [15:0] crc;
        logic [15:0] sum;
    } t_codes;

    localparam t_codes CODES_INIT = '{parity: 1'b0, crc: CRC_INIT, sum: SUM_INIT};

    // CRC-16, MSB first, eight bit steps on one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // 16-bit sum with end-around carry
    function automatic logic [15:0] sum_byte(input logic [15:0] sum, input logic [7:0] b);
        logic [16:0] t;
        t = {1'b0, sum} + {9'd0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// File: rtl/fec_accum.sv
// Running parity, CRC and sum accumulators for the current frame.
// Depends on fec_pkg.
module fec_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_last,
    input  logic [7:0]      i_byte,
    output fec_pkg::t_codes o_next,
    output fec_pkg::t_codes o_acc
);
    import fec_pkg::*;

    t_codes r_acc;
    t_codes n_acc;

    always_comb begin
        n_acc.parity = r_acc.parity ^ (^i_byte);
        n_acc.crc    = crc_byte(r_acc.crc, i_byte);
        n_acc.sum    = sum_byte(r_acc.sum, i_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= CODES_INIT;
        end else if (i_adv) begin
            // restart on the closing byte
            r_acc <= i_last ? CODES_INIT : n_acc;
        end
    end

    assign o_next = n_acc;
    assign o_acc  = r_acc;

endmodule

// File: rtl/fec_result.sv
// Code selection, compare and the result register of the frame checker.
// Depends on fec_pkg.
module fec_result (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_take,
    input  logic [1:0]      i_method,
    input  fec_pkg::t_codes i_codes,
    input  logic [15:0]     i_sent,
    output logic            o_valid,
    output logic [15:0]     o_code,
    output logic            o_match
);
    import fec_pkg::*;

    logic        r_valid;
    logic [15:0] r_code;
    logic        r_match;
    logic [15:0] n_code;
    logic        n_match;

    always_comb begin
        case (i_method)
            METH_PARITY: begin
                n_code  = {15'd0, i_codes.parity};
                n_match = (n_code == i_sent);
            end
            METH_CRC: begin
                n_code  = i_codes.crc;
                n_match = (n_code == i_sent);
            end
            METH_SUM: begin
                n_code  = ~i_codes.sum;
                n_match = (n_code == i_sent);
            end
            default: begin
                n_code  = 16'd0;
                n_match = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code  <= n_code;
            r_match <= n_match;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_match = r_match;

endmodule

// File: rtl/frame_error_check_verifier.sv
// Frame error check verifier: top level. Depends on fec_pkg, fec_accum, fec_result.
// A closing byte goes through the input register, then the result register. Throughput:
// one byte per cycle, but a closing byte waits while the result slot is full; the rate
// is set by the combinational byte-wide CRC/sum update between the two registers.
// Reset (synchronous, active low): method to even parity, codes to start values.
`include "frame_error_check_verifier_defines.svh"

module frame_error_check_verifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: check method, 0 parity, 1 CRC-16, 2 checksum
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] sent_code
    input  logic        s_axis_tlast,   // frame_end
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] computed_code, [16] code_match, rest zero
);
    import fec_pkg::*;

    // Method register; the user must write it only while idle, the block does not enforce this.
    logic [1:0]  r_method;

    // Input register: hold one beat until it can move on.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_in_sent;

    logic        out_free;
    logic        adv;
    logic        in_fire;
    logic        out_fire;
    logic        load_result;
    t_codes      codes_next;
    t_codes      codes_acc;
    logic        res_valid;
    logic [15:0] res_code;
    logic        res_match;

    // A middle byte moves on at once; a closing byte waits for a free result slot.
    assign out_fire      = m_axis_tvalid & m_axis_tready;
    assign out_free      = !res_valid || m_axis_tready;
    assign adv           = r_in_valid && (!r_in_last || out_free);
    assign load_result   = adv && r_in_last;
    assign s_axis_tready = !r_in_valid || adv;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METH_PARITY;
        end else if (i_cfg_wr_en) begin
            r_method <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: load on every accepted beat, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_last <= s_axis_tlast;
            r_in_sent <= s_axis_tdata[23:8];
        end
    end

    fec_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_last  (r_in_last),
        .i_byte  (r_in_byte),
        .o_next  (codes_next),
        .o_acc   (codes_acc)
    );

    // Codes including the closing byte feed the compare directly.
    fec_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_result),
        .i_take   (m_axis_tready),
        .i_method (r_method),
        .i_codes  (codes_next),
        .i_sent   (r_in_sent),
        .o_valid  (res_valid),
        .o_code   (res_code),
        .o_match  (res_match)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {7'd0, res_match, res_code};

    // A closing byte always leaves a result behind it.
    `FEC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, load_result, m_axis_tvalid, "closing byte left no result")
    // Accumulators restart after a closing byte.
    `FEC_ASSERT_NEXT(a_acc_restart, i_clk, i_rst_n, load_result, codes_acc == CODES_INIT, "accumulators not restarted after frame end")
    // Back-pressure only while a beat is held.
    `FEC_ASSERT_NOW(a_stall_needs_beat, i_clk, i_rst_n, !s_axis_tready, r_in_valid, "input stalled with empty input register")
    // A handed-over result is not shown again; only a newly loaded one refills the slot.
    `FEC_ASSERT_NEXT(a_result_drain, i_clk, i_rst_n, out_fire && !load_result, !m_axis_tvalid, "result repeated after hand-over")

endmodule

// File: bench/fec_frame_checker.sv
// Scoreboard for the frame error check verifier: tracks the check method and
// the running frame codes, and compares every result beat in order.
// Depends on fec_pkg for the method codes and the code start values.
module fec_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,      // [7:0] data_byte, [23:8] sent_code
    input  logic        i_in_last,      // frame_end
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,     // [15:0] computed_code, [16] code_match
    output int          o_err_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] code;
        logic        match;
    } t_frame_verdict;

    logic [1:0]     method_q;
    logic           par_q;
    logic [15:0]    crc_q;
    logic [15:0]    sum_q;
    t_frame_verdict verdict_q[$];
    int             err_cnt = 0;

    assign o_err_count = err_cnt;

    // CRC-16 0x1021, one data bit at a time into the top of the register
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ fec_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // carry out of bit 15 folds back into bit 0; it cannot carry twice
    function automatic logic [15:0] sum_next(input logic [15:0] sum, input logic [7:0] b);
        logic [16:0] t;
        t = {1'b0, sum} + {9'd0, b};
        return t[16] ? t[15:0] + 16'd1 : t[15:0];
    endfunction

    function automatic logic [15:0] code_for(input logic [1:0] method, input logic par,
                                             input logic [15:0] crc, input logic [15:0] sum);
        case (method)
            fec_pkg::METH_PARITY: return {15'd0, par};
            fec_pkg::METH_CRC:    return crc;
            fec_pkg::METH_SUM:    return ~sum;
            default:              return 16'd0;
        endcase
    endfunction

    task automatic report_fault(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_verdict want;
        logic           p;
        logic [15:0]    c;
        logic [15:0]    s;
        if (!i_rst_n) begin
            method_q = fec_pkg::METH_PARITY;
            par_q    = 1'b0;
            crc_q    = fec_pkg::CRC_INIT;
            sum_q    = fec_pkg::SUM_INIT;
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_fault($sformatf("result beat %h with no frame closed", i_out_data));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data[15:0] !== want.code) begin
                        report_fault($sformatf("computed_code %h, expected %h",
                                               i_out_data[15:0], want.code));
                    end
                    if (i_out_data[16] !== want.match) begin
                        report_fault($sformatf("code_match %b, expected %b",
                                               i_out_data[16], want.match));
                    end
                    if (i_out_data[23:17] !== 7'd0) begin
                        report_fault($sformatf("padding bits %h not zero", i_out_data[23:17]));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                method_q = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                p = par_q ^ (^i_in_data[7:0]);
                c = crc_next(crc_q, i_in_data[7:0]);
                s = sum_next(sum_q, i_in_data[7:0]);
                if (i_in_last) begin
                    // the method in force on the closing byte decides; the spare code never matches
                    want.code  = code_for(method_q, p, c, s);
                    want.match = (method_q == fec_pkg::METH_PARITY ||
                                  method_q == fec_pkg::METH_CRC ||
                                  method_q == fec_pkg::METH_SUM) &&
                                 (want.code == i_in_data[23:8]);
                    verdict_q.push_back(want);
                    par_q = 1'b0;
                    crc_q = fec_pkg::CRC_INIT;
                    sum_q = fec_pkg::SUM_INIT;
                end else begin
                    par_q = p;
                    crc_q = c;
                    sum_q = s;
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// File: bench/tb_top.sv
// Top of the frame error check verifier bench: clock, reset, byte stimulus,
// method writes and the verdict. Depends on fec_pkg, the block and fec_frame_checker.
module tb_top;

    // method code with no check behind it: result must be code 0, no match
    localparam logic [1:0] METH_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    // the block holds a byte in its input and result registers; leave a margin on top
    localparam int         SETTLE      = 4;
    localparam int         PHASE_BEATS = 110;
    localparam int         PHASES      = 8;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [1:0]  i_cfg_wr_data   = 2'd0;
    logic        s_axis_tvalid   = 1'b0;
    logic [23:0] s_axis_tdata    = 24'd0;
    logic        s_axis_tlast    = 1'b0;
    logic        m_axis_tready   = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [23:0] m_axis_tdata;

    int          err_count;
    int          pending;
    int          cycles          = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          beats_sent      = 0;

    // sender's own view of the open frame, used to build correct control values
    logic [1:0]  cur_method      = fec_pkg::METH_PARITY;
    logic        frame_par       = 1'b0;
    logic [15:0] frame_crc       = fec_pkg::CRC_INIT;
    logic [15:0] frame_sum       = fec_pkg::SUM_INIT;

    int          send_idle_tab[4]  = '{0, 61, 0, 6};
    int          recv_stall_tab[4] = '{0, 0, 61, 6};
    logic [1:0]  phase_method[PHASES] = '{fec_pkg::METH_PARITY, fec_pkg::METH_SUM,
                                          fec_pkg::METH_CRC, METH_SPARE,
                                          fec_pkg::METH_SUM, fec_pkg::METH_CRC,
                                          fec_pkg::METH_PARITY, fec_pkg::METH_CRC};

    frame_error_check_verifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fec_frame_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: stall at the rate of the current phase, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // code the block should report if this byte closed the open frame
    function automatic logic [15:0] closing_code(input logic [7:0] b);
        return chk.code_for(cur_method, frame_par ^ (^b),
                            chk.crc_next(frame_crc, b), chk.sum_next(frame_sum, b));
    endfunction

    // offer one beat, after a random idle gap, and hold it until accepted
    task automatic push_byte(input logic [7:0] b, input logic last, input logic [15:0] sent);
        if (last) begin
            frame_par = 1'b0;
            frame_crc = fec_pkg::CRC_INIT;
            frame_sum = fec_pkg::SUM_INIT;
        end else begin
            frame_par = frame_par ^ (^b);
            frame_crc = chk.crc_next(frame_crc, b);
            frame_sum = chk.sum_next(frame_sum, b);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sent, b};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // random frame body; heavy frames are long runs of large bytes to force the
    // checksum carry to wrap; an unclosed frame is carried into the next phase
    task automatic send_frame(input int len, input bit close, input bit heavy);
        logic [7:0]  b;
        logic [15:0] sent;
        logic        last;
        for (int k = 0; k < len; k++) begin
            if (heavy) begin
                b = 8'($urandom_range(255, 224));
            end else begin
                case ($urandom_range(9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom());
                endcase
            end
            last = close && (k == len - 1);
            if (last && $urandom_range(1)) begin
                sent = closing_code(b);
            end else begin
                case ($urandom_range(3))
                    0:       sent = closing_code(b) ^ (16'd1 << $urandom_range(15));
                    1:       sent = 16'($urandom_range(1));
                    2:       sent = 16'hFFFF;
                    default: sent = 16'($urandom());
                endcase
            end
            push_byte(b, last, sent);
        end
    endtask

    // drop valid, wait for every closed frame to report, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // only ever called with the block idle
    task automatic write_method(input logic [1:0] m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_method     = m;
    endtask

    initial begin : stimulus
        int  goal;
        int  len;
        bit  wrap_done;
        wrap_done = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // parity under the reset method: matches need sent_code of 0 or 1,
        // so an all-ones control value must fail
        push_byte(8'h00, 1'b1, 16'h0000);
        push_byte(8'hFF, 1'b1, 16'hFFFF);
        push_byte(8'h80, 1'b1, 16'h0001);
        push_byte(8'h01, 1'b1, 16'h0000);
        settle();

        // CRC check string "123456789" gives the well-known 29B1
        write_method(fec_pkg::METH_CRC);
        for (int k = 1; k <= 8; k++) begin
            push_byte(8'h30 + k[7:0], 1'b0, 16'h0000);
        end
        push_byte(8'h39, 1'b1, 16'h29B1);
        push_byte(8'hFF, 1'b1, 16'h0000);
        settle();

        // checksum: extremes of the byte, and an all-zero frame giving FFFF
        write_method(fec_pkg::METH_SUM);
        push_byte(8'hFF, 1'b0, 16'h0000);
        push_byte(8'hFF, 1'b1, closing_code(8'hFF));
        push_byte(8'h00, 1'b1, 16'hFFFF);
        settle();

        // spare method: code 0 against a sent 0 still reports no match;
        // leave a frame open and switch method before closing it
        write_method(METH_SPARE);
        push_byte(8'h00, 1'b1, 16'h0000);
        push_byte(8'hFF, 1'b0, 16'h1234);
        settle();
        write_method(fec_pkg::METH_CRC);
        push_byte(8'h12, 1'b1, closing_code(8'h12));
        settle();

        // random phases: each with its own method and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            write_method(phase_method[ph]);
            send_idle_pct  = send_idle_tab[ph % 4];
            recv_stall_pct = recv_stall_tab[ph % 4];
            goal = beats_sent + PHASE_BEATS;
            if (phase_method[ph] == fec_pkg::METH_SUM && !wrap_done) begin
                send_frame($urandom_range(340, 300), 1'b1, 1'b1);
                wrap_done = 1'b1;
            end
            while (beats_sent < goal) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                send_frame(len, 1'b1, 1'b0);
            end
            // sometimes carry an open frame across the method change
            if ($urandom_range(1)) begin
                send_frame($urandom_range(3, 1), 1'b0, 1'b0);
            end
            settle();
        end

        // close any frame still open, then give the verdict
        send_frame(1, 1'b1, 1'b0);
        settle();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
